// ===== design/read_priority_event_queue_defines.svh =====
// Assertion helpers used by the queue controller (rpeq_ctrl).
// Each expects clk and rst in scope.
`ifndef READ_PRIORITY_EVENT_QUEUE_DEFINES_SVH
`define READ_PRIORITY_EVENT_QUEUE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define RPEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RPEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rpeq_pkg.sv =====
package rpeq_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_TAG_BITS    = 16;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_FLUSH   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Shift command broadcast to every slot cell.
  typedef struct packed {
    logic ins;  // open a hole at the insert position, shift later slots back
    logic deq;  // shift every slot one place towards the head
  } cmd_t;

endpackage

// ===== design/rpeq_cell.sv =====
module rpeq_cell
  import rpeq_pkg::*;
#(
  parameter int TAG_BITS = DEF_TAG_BITS,
  parameter int PW       = 6,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  cmd_t                cmd,
  input  logic [PW-1:0]       pos,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic [TAG_BITS-1:0] prev_tag,
  input  logic [TAG_BITS-1:0] succ_tag,
  output logic [TAG_BITS-1:0] tag
);

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  always_ff @(posedge clk) begin
    if (cmd.deq) begin
      tag <= succ_tag;
    end else if (cmd.ins) begin
      if (pos == MY_POS) begin
        tag <= new_tag;
      end else if (MY_POS > pos) begin
        tag <= prev_tag;
      end
    end
  end

endmodule

// ===== design/rpeq_ctrl.sv =====
`include "read_priority_event_queue_defines.svh"

module rpeq_ctrl
  import rpeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int PW = $clog2(QUEUE_DEPTH),
  parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          func,
  input  logic [1:0]    io_kind,
  output cmd_t          cmd,
  output logic [PW-1:0] pos,
  output status_t       status,
  output logic [CW-1:0] count_next,
  output logic [CW-1:0] span_next
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  logic [CW-1:0] occupancy;
  logic [CW-1:0] occupancy_next;
  logic [PW-1:0] last_read_pos;
  logic [PW-1:0] last_read_pos_next;
  logic          last_read_valid;
  logic          last_read_valid_next;

  always_comb begin
    cmd                  = '0;
    pos                  = '0;
    status               = ST_OK;
    occupancy_next       = occupancy;
    last_read_pos_next   = last_read_pos;
    last_read_valid_next = last_read_valid;
    if (accept) begin
      if (func == FUNC_DEQ) begin
        if (occupancy == '0) begin
          status = ST_EMPTY;
        end else begin
          cmd.deq        = 1'b1;
          occupancy_next = occupancy - CW'(1);
          if (last_read_valid) begin
            if (last_read_pos == '0) begin
              last_read_valid_next = 1'b0;
            end else begin
              last_read_pos_next = last_read_pos - PW'(1);
            end
          end
        end
      end else if (occupancy == FULL_COUNT) begin
        status = ST_FULL;
      end else begin
        cmd.ins        = 1'b1;
        occupancy_next = occupancy + CW'(1);
        case (kind_t'(io_kind))
          KIND_FLUSH: begin
            pos = '0;
            if (last_read_valid) begin
              last_read_pos_next = last_read_pos + PW'(1);
            end
          end
          KIND_READ: begin
            // just behind the last queued read; the mark always lies below occupancy
            pos                  = last_read_valid ? last_read_pos + PW'(1) : '0;
            last_read_valid_next = 1'b1;
            last_read_pos_next   = pos;
          end
          default: begin
            pos = occupancy[PW-1:0];
          end
        endcase
      end
    end
  end

  assign count_next = occupancy_next;
  assign span_next  = last_read_valid_next ? CW'(last_read_pos_next) + CW'(1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy       <= '0;
      last_read_pos   <= '0;
      last_read_valid <= 1'b0;
    end else begin
      occupancy       <= occupancy_next;
      last_read_pos   <= last_read_pos_next;
      last_read_valid <= last_read_valid_next;
    end
  end

  `RPEQ_ASSERT_SAME(a_mark_inside, last_read_valid, CW'(last_read_pos) < occupancy, "read mark beyond occupancy")
  `RPEQ_ASSERT_SAME(a_mark_cleared, !last_read_valid, last_read_pos == '0, "stale read position")
  `RPEQ_ASSERT_NEXT(a_deq_count, accept && func == FUNC_DEQ && occupancy != '0, occupancy == $past(occupancy) - CW'(1), "dequeue miscounted")
  `RPEQ_ASSERT_NEXT(a_full_hold, accept && func == FUNC_ENQ && occupancy == FULL_COUNT, occupancy == FULL_COUNT && $stable(last_read_pos), "full queue changed")

endmodule

// ===== design/read_priority_event_queue.sv =====
// Read-priority event queue.
// Input channel: in_valid / in_stall carry one request of func, io_kind and
// event_tag. func 0 enqueues event_tag; func 1 dequeues the head tag. Reads go
// in behind the last queued read (or at the head), flushes go in at the head,
// writes and discards go to the tail.
// Output channel: out_valid / out_stall carry one result per request: status,
// head_tag (dequeued tag, else 0), entry_count and read_span.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle unless a stalled result holds the input;
// every slot cell shifts in parallel, so the chain of cells sets no extra delay.
// A dequeue from an empty queue reports status 1, an enqueue into a full queue
// reports status 2; neither changes the queue.
// Stall: while a result waits with out_stall high, in_stall is raised and the
// queue holds; a result taken in the same cycle frees room for a new request.
// Reset (rst, synchronous): the queue is emptied and the read mark cleared;
// slot contents are left as they are and never read before written.
module read_priority_event_queue
  import rpeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 func,
  input  logic [1:0]                           io_kind,
  input  logic [TAG_BITS-1:0]                  event_tag,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           status,
  output logic [TAG_BITS-1:0]                  head_tag,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   entry_count,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   read_span
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                accept;
  cmd_t                cmd;
  logic [PW-1:0]       pos;
  status_t             status_next;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       span_next;
  logic [TAG_BITS-1:0] slot [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] prev_tag [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] succ_tag [QUEUE_DEPTH];

  // Hold new requests while an untaken result sits in the output register.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  rpeq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PW          (PW),
    .CW          (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (func),
    .io_kind    (io_kind),
    .cmd        (cmd),
    .pos        (pos),
    .status     (status_next),
    .count_next (count_next),
    .span_next  (span_next)
  );

  // Row of slot cells, slot 0 at the head; each cell sees both neighbours.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_tag[i] = '0;
    end else begin : g_inner
      assign prev_tag[i] = slot[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign succ_tag[i] = '0;
    end else begin : g_body
      assign succ_tag[i] = slot[i+1];
    end

    rpeq_cell #(
      .TAG_BITS (TAG_BITS),
      .PW       (PW),
      .IDX      (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (pos),
      .new_tag  (event_tag),
      .prev_tag (prev_tag[i]),
      .succ_tag (succ_tag[i]),
      .tag      (slot[i])
    );
  end

  // Output register: load on every accepted request, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      head_tag    <= cmd.deq ? slot[0] : '0;
      entry_count <= count_next;
      read_span   <= span_next;
    end
  end

endmodule

// ===== bench/read_priority_event_queue_checker.sv =====
module read_priority_event_queue_checker
  import rpeq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    func,
  input  logic [1:0]              io_kind,
  input  logic [DEF_TAG_BITS-1:0] event_tag,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [1:0]              status,
  input  logic [DEF_TAG_BITS-1:0] head_tag,
  input  logic [6:0]              entry_count,
  input  logic [6:0]              read_span,
  output int                      fail_count,
  output int                      pending,
  output int                      checked
);

  typedef struct packed {
    status_t                 st;
    logic [DEF_TAG_BITS-1:0] head;
    logic [6:0]              count;
    logic [6:0]              span;
  } outcome_t;

  // Shadow copy of the queue; slot 0 is the head.
  logic [DEF_TAG_BITS-1:0] tags [DEF_QUEUE_DEPTH];
  int unsigned held;
  int unsigned mark_pos;
  bit          mark_valid;
  outcome_t    due_outcomes [$];

  function automatic void insert_tag(int unsigned pos, logic [DEF_TAG_BITS-1:0] tag);
    for (int i = held; i > pos; i--) tags[i] = tags[i-1];
    tags[pos] = tag;
    held++;
  endfunction

  // Apply one request to the shadow queue and return the result it should give.
  function automatic outcome_t apply_request(logic f, kind_t k, logic [DEF_TAG_BITS-1:0] tag);
    outcome_t    o;
    int unsigned pos;
    o.st   = ST_OK;
    o.head = '0;
    if (f == FUNC_DEQ) begin
      if (held == 0) begin
        o.st = ST_EMPTY;
      end else begin
        o.head = tags[0];
        for (int i = 0; i + 1 < held; i++) tags[i] = tags[i+1];
        held--;
        if (mark_valid) begin
          if (mark_pos == 0) mark_valid = 1'b0;
          else mark_pos--;
        end
      end
    end else if (held >= DEF_QUEUE_DEPTH) begin
      o.st = ST_FULL;
    end else if (held == 0) begin
      insert_tag(0, tag);
      if (k == KIND_READ) begin
        mark_valid = 1'b1;
        mark_pos   = 0;
      end
    end else if (k == KIND_FLUSH) begin
      insert_tag(0, tag);
      if (mark_valid) mark_pos++;
    end else if (k == KIND_READ) begin
      pos = mark_valid ? mark_pos + 1 : 0;
      if (pos > held) pos = held;
      insert_tag(pos, tag);
      mark_valid = 1'b1;
      mark_pos   = pos;
    end else begin
      insert_tag(held, tag);
    end
    o.count = 7'(held);
    o.span  = mark_valid ? 7'(mark_pos + 1) : 7'd0;
    return o;
  endfunction

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      held       = 0;
      mark_pos   = 0;
      mark_valid = 1'b0;
      due_outcomes.delete();
      pending    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_outcomes.size() == 0) begin
          flag_mismatch($sformatf({"result with nothing due: status %0d head %h ",
                                   "count %0d span %0d"},
                                  status, head_tag, entry_count, read_span));
        end else begin
          want = due_outcomes.pop_front();
          checked++;
          if (status !== want.st || head_tag !== want.head ||
              entry_count !== want.count || read_span !== want.span)
            flag_mismatch($sformatf({"result %0d: expected status %0d head %h count %0d ",
                                     "span %0d, got status %0d head %h count %0d span %0d"},
                                    checked, want.st, want.head, want.count, want.span,
                                    status, head_tag, entry_count, read_span));
        end
      end
      if (in_valid && !in_stall)
        due_outcomes.push_back(apply_request(func, kind_t'(io_kind), event_tag));
      pending = due_outcomes.size();
    end
  end

endmodule

// ===== bench/read_priority_event_queue_tb.sv =====
module read_priority_event_queue_tb
  import rpeq_pkg::*;
();

  localparam int HOLD_CYCLES = 150;      // long output hold-off
  localparam int LIMIT       = 400000;   // time units, far beyond the slowest run

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic                    func;
  logic [1:0]              io_kind;
  logic [DEF_TAG_BITS-1:0] event_tag;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              status;
  logic [DEF_TAG_BITS-1:0] head_tag;
  logic [6:0]              entry_count;
  logic [6:0]              read_span;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_served;

  int send_idle_mix [4] = '{0, 51, 0, 37};
  int stall_mix     [4] = '{0, 0, 51, 37};

  read_priority_event_queue uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .io_kind     (io_kind),
    .event_tag   (event_tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .head_tag    (head_tag),
    .entry_count (entry_count),
    .read_span   (read_span)
  );

  read_priority_event_queue_checker queue_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .io_kind     (io_kind),
    .event_tag   (event_tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .head_tag    (head_tag),
    .entry_count (entry_count),
    .read_span   (read_span),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stall at random by stall_pct; when asked, hold off for a long
  // stretch so the queue's output register fills and the input stalls.
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        holds_served++;
      end
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one request: idle for a random number of cycles, then raise valid
  // with the payload at the falling edge and hold it until accepted.
  task automatic push_request(input logic f, input kind_t k,
                              input logic [DEF_TAG_BITS-1:0] tag);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    io_kind   <= k;
    event_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Random request; enq_pct biases towards filling or draining the queue.
  task automatic random_request(input int enq_pct);
    logic                    f;
    logic [DEF_TAG_BITS-1:0] tag;
    f = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
    case ($urandom_range(7))
      0:       tag = '0;
      1:       tag = '1;
      default: tag = DEF_TAG_BITS'($urandom_range(16'hFFFF));
    endcase
    push_request(f, kind_t'($urandom_range(3)), tag);
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = FUNC_ENQ;
    io_kind       = KIND_READ;
    event_tag     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: dequeue from empty, then build a queue mixing every event type.
    push_request(FUNC_DEQ, KIND_READ,    16'h0000);
    push_request(FUNC_ENQ, KIND_READ,    16'hFFFF);  // read into empty queue
    push_request(FUNC_ENQ, KIND_WRITE,   16'h0000);
    push_request(FUNC_ENQ, KIND_DISCARD, 16'h1234);
    push_request(FUNC_ENQ, KIND_READ,    16'h0001);  // behind the last read
    push_request(FUNC_ENQ, KIND_FLUSH,   16'h8000);  // ahead of queued reads
    push_request(FUNC_ENQ, KIND_READ,    16'hAAAA);
    // Drain through the reads; the last one clears the read mark.
    push_request(FUNC_DEQ, KIND_WRITE,   16'hFFFF);
    push_request(FUNC_DEQ, KIND_READ,    16'h0000);
    push_request(FUNC_DEQ, KIND_FLUSH,   16'h5A5A);
    push_request(FUNC_DEQ, KIND_DISCARD, 16'hA5A5);
    // No read queued but the queue is not empty: read goes to the head.
    push_request(FUNC_ENQ, KIND_READ,    16'h5555);
    push_request(FUNC_DEQ, KIND_READ,    16'h0000);
    push_request(FUNC_ENQ, KIND_WRITE,   16'h7FFF);
    push_request(FUNC_DEQ, KIND_READ,    16'h0000);
    push_request(FUNC_DEQ, KIND_READ,    16'h0000);
    push_request(FUNC_DEQ, KIND_READ,    16'h0000);
    push_request(FUNC_DEQ, KIND_FLUSH,   16'hFFFF);  // dequeue from the empty queue
    push_request(FUNC_ENQ, KIND_FLUSH,   16'h7FFF);  // flush into empty queue
    push_request(FUNC_ENQ, KIND_FLUSH,   16'hFFFE);
    push_request(FUNC_DEQ, KIND_WRITE,   16'h0000);
    push_request(FUNC_DEQ, KIND_WRITE,   16'h0000);
    settle();

    // Random: per idling mix, fill hard then drain part way.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_mix[ph];
      stall_pct     = stall_mix[ph];
      repeat (55) random_request(95);
      repeat (30) random_request(10);
      settle();
    end

    // Long hold-off on the output while requests keep coming back to back.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests++;
    repeat (20) random_request(70);
    settle();

    // Drain to empty and beyond, so empty dequeues show up under idling too.
    send_idle_pct = 37;
    stall_pct     = 37;
    repeat (70) random_request(0);
    settle();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests over four idling mixes, a long output hold-off and a full drain;",
             sent);
    $display("%0d results compared, %0d mismatching, %0d still outstanding.",
             checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("read_priority_event_queue verification clean");
    end else begin
      $display("read_priority_event_queue verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #LIMIT;
    $display("Timed out with %0d results outstanding.", pending);
    $display("read_priority_event_queue verification failed");
    $finish;
  end

endmodule
